@@ sv/kssp_pkg.sv @@
package kssp_pkg;

   localparam int SCRIPT_DEPTH = 4096;
   localparam int SCRIPT_AW    = $clog2(SCRIPT_DEPTH);
   localparam int IDX_W        = $clog2(SCRIPT_DEPTH + 1);

   // Sequencer phases.
   localparam logic [3:0] PH_IDLE         = 4'd0;
   localparam logic [3:0] PH_START        = 4'd1;
   localparam logic [3:0] PH_FETCH        = 4'd2;
   localparam logic [3:0] PH_KEY_DOWN     = 4'd3;
   localparam logic [3:0] PH_KEY_UP       = 4'd4;
   localparam logic [3:0] PH_MOD_DOWN     = 4'd5;
   localparam logic [3:0] PH_MOD_KEY_DOWN = 4'd6;
   localparam logic [3:0] PH_MOD_KEY_UP   = 4'd7;
   localparam logic [3:0] PH_MOD_UP       = 4'd8;
   localparam logic [3:0] PH_WAIT         = 4'd9;

   // Event codes on the result channel.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_KEY_DOWN = 3'd1;
   localparam logic [2:0] EV_KEY_UP   = 3'd2;
   localparam logic [2:0] EV_MOD_DOWN = 3'd3;
   localparam logic [2:0] EV_MOD_UP   = 3'd4;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic CSR_TICK_DIVIDE = 1'b0;
   localparam logic CSR_DEBOUNCE    = 1'b1;

   localparam logic [7:0] TICK_DIVIDE_RESET = 8'd2;
   localparam logic [9:0] DEBOUNCE_RESET    = 10'd100;
   localparam logic [7:0] TOKEN_END         = 8'hFE;
   localparam logic [7:0] TOKEN_WAIT        = 8'h00;

   typedef struct packed {
      logic        op;
      logic        kbd_enabled;
      logic        button_pressed;
      logic [11:0] script_addr;
      logic [15:0] script_word;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] key_code;
      logic [7:0] modifier;
      logic       activity_led;
      logic       running;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] tick_divide;
      logic [9:0] debounce_periods;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       tick_count;
      logic [3:0]       phase;
      logic [7:0]       wait_count;
      logic [9:0]       debounce_count;
      logic [15:0]      current_token;
      logic [IDX_W-1:0] script_index;
      logic             led_state;
   } seq_state_type;

endpackage

@@ sv/kssp_req_if.sv @@
interface kssp_req_if;
   logic                     valid;
   logic                     ready;
   kssp_pkg::req_payload_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

@@ sv/kssp_rsp_if.sv @@
interface kssp_rsp_if;
   logic                     valid;
   logic                     ready;
   kssp_pkg::rsp_payload_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

@@ sv/keystroke_script_player_core.sv @@
// Channel   Dir  Handshake     Carries
// req_chan  in   valid/ready   tick or script write item
// rsp_chan  out  valid/ready   one result item per request item
// csr_*     in   write enable  tick_divide, debounce_periods
//
// One item is taken every cycle unless the result register stalls; its result register loads when it commits.
// The script memory read is registered; it is issued when the item is taken,
// using the script index that the item ahead of it leaves.
// Reset is synchronous; playback starts at index 0 after reset, with no clearing pass.
// A stalled result register holds the item in the execute stage, which stops intake.
module keystroke_script_player_core (
   input  logic                                  clock,
   input  logic                                  reset,
   kssp_req_if.sink                              req_chan,
   kssp_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [9:0]                            csr_wdata
);

   logic [15:0] script_mem [kssp_pkg::SCRIPT_DEPTH];
   logic [15:0] rd_data_ff;

   kssp_pkg::cfg_type         cfg_ff;
   kssp_pkg::seq_state_type   state_ff;
   kssp_pkg::seq_state_type   state_in;
   kssp_pkg::seq_state_type   step_state;
   kssp_pkg::req_payload_type exec_item_ff;
   kssp_pkg::rsp_payload_type step_res;
   kssp_pkg::rsp_payload_type out_data_ff;
   logic                      exec_valid_ff;
   logic                      out_valid_ff;
   logic                      commit;
   logic                      accept;
   logic [kssp_pkg::IDX_W-1:0] rd_index;

   kssp_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (exec_item_ff),
      .rd_data    (rd_data_ff),
      .state_next (step_state),
      .result     (step_res)
   );

   assign commit         = exec_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !exec_valid_ff || commit;
   assign accept         = req_chan.valid && req_chan.ready;
   assign state_in       = commit ? step_state : state_ff;
   // The item being taken reads at the index its predecessor leaves behind.
   assign rd_index       = state_in.script_index;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_chan.data.op == kssp_pkg::OP_WRITE) begin
            if (32'(req_chan.data.script_addr) < kssp_pkg::SCRIPT_DEPTH) begin
               script_mem[kssp_pkg::SCRIPT_AW'(req_chan.data.script_addr)] <=
                  req_chan.data.script_word;
            end
         end else begin
            rd_data_ff <= script_mem[rd_index[kssp_pkg::SCRIPT_AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         exec_item_ff <= req_chan.data;
      end
      if (commit) begin
         out_data_ff <= step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cfg_ff.tick_divide      <= kssp_pkg::TICK_DIVIDE_RESET;
         cfg_ff.debounce_periods <= kssp_pkg::DEBOUNCE_RESET;
         state_ff <= '{tick_count: '0, phase: kssp_pkg::PH_START, wait_count: '0,
                       debounce_count: '0, current_token: '0, script_index: '0,
                       led_state: 1'b0};
      end else begin
         if (accept) begin
            exec_valid_ff <= 1'b1;
         end else if (commit) begin
            exec_valid_ff <= 1'b0;
         end
         if (commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               kssp_pkg::CSR_TICK_DIVIDE: cfg_ff.tick_divide      <= csr_wdata[7:0];
               kssp_pkg::CSR_DEBOUNCE:    cfg_ff.debounce_periods <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Key and modifier events come only from the key and modifier phases.
   assert property (@(posedge clock) disable iff (reset)
      commit && step_res.event_res != kssp_pkg::EV_NONE |->
         state_ff.phase >= kssp_pkg::PH_KEY_DOWN && state_ff.phase <= kssp_pkg::PH_MOD_UP)
      else $error("event emitted outside a key or modifier phase");

   // The script index only holds, advances by one or restarts from zero.
   assert property (@(posedge clock) disable iff (reset)
      commit |=> state_ff.script_index == $past(state_ff.script_index) ||
                 state_ff.script_index == $past(state_ff.script_index) + 1'b1 ||
                 state_ff.script_index == '0)
      else $error("script index jumped");

   // A result that cannot leave keeps its item in the execute stage.
   assert property (@(posedge clock) disable iff (reset)
      exec_valid_ff && out_valid_ff && !rsp_chan.ready |=>
         exec_valid_ff && $stable(state_ff))
      else $error("execute stage lost an item under stall");

   // State changes only when an item completes.
   assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(state_ff))
      else $error("sequencer state changed without an item");

endmodule

@@ sv/kssp_step.sv @@
module kssp_step (
   input  kssp_pkg::seq_state_type   state,
   input  kssp_pkg::cfg_type         cfg,
   input  kssp_pkg::req_payload_type item,
   input  logic [15:0]               rd_data,
   output kssp_pkg::seq_state_type   state_next,
   output kssp_pkg::rsp_payload_type result
);

   always_comb begin : step_logic
      logic [7:0]                 tick_inc;
      logic [7:0]                 lo;
      logic [7:0]                 hi;
      logic [7:0]                 new_lo;
      logic [7:0]                 new_hi;
      logic [kssp_pkg::IDX_W-1:0] idx_inc;

      state_next = state;
      result     = '0;
      tick_inc   = state.tick_count + 8'd1;
      lo         = state.current_token[7:0];
      hi         = state.current_token[15:8];
      new_lo     = rd_data[7:0];
      new_hi     = rd_data[15:8];
      idx_inc    = state.script_index + kssp_pkg::IDX_W'(1);

      if (item.op == kssp_pkg::OP_TICK && item.kbd_enabled) begin
         if (tick_inc >= cfg.tick_divide) begin
            state_next.tick_count = '0;
            if (state.debounce_count != '0) begin
               state_next.debounce_count = state.debounce_count - 10'd1;
            end

            case (state.phase)
               kssp_pkg::PH_IDLE: begin
                  state_next.led_state = 1'b0;
                  // The button restarts only once the debounce window has run out.
                  if (item.button_pressed && state_next.debounce_count == '0) begin
                     state_next.phase          = kssp_pkg::PH_START;
                     state_next.script_index   = '0;
                     state_next.debounce_count = cfg.debounce_periods;
                  end
               end
               kssp_pkg::PH_START: begin
                  state_next.phase = kssp_pkg::PH_FETCH;
               end
               kssp_pkg::PH_FETCH: begin
                  if (state.script_index >= kssp_pkg::IDX_W'(kssp_pkg::SCRIPT_DEPTH)) begin
                     state_next.phase = kssp_pkg::PH_IDLE;
                  end else begin
                     state_next.current_token = rd_data;
                     state_next.script_index  = idx_inc;
                     state_next.led_state     = ~idx_inc[0];
                     if (new_lo == kssp_pkg::TOKEN_END) begin
                        state_next.phase          = kssp_pkg::PH_IDLE;
                        state_next.debounce_count = '0;
                     end else if (new_lo == kssp_pkg::TOKEN_WAIT) begin
                        state_next.wait_count = new_hi;
                        state_next.phase      = kssp_pkg::PH_WAIT;
                     end else if (new_hi == 8'h00) begin
                        state_next.phase = kssp_pkg::PH_KEY_DOWN;
                     end else begin
                        state_next.phase = kssp_pkg::PH_MOD_DOWN;
                     end
                  end
               end
               kssp_pkg::PH_KEY_DOWN: begin
                  result.event_res = kssp_pkg::EV_KEY_DOWN;
                  result.key_code  = lo;
                  state_next.phase = kssp_pkg::PH_KEY_UP;
               end
               kssp_pkg::PH_KEY_UP: begin
                  result.event_res = kssp_pkg::EV_KEY_UP;
                  result.key_code  = lo;
                  state_next.phase = kssp_pkg::PH_FETCH;
               end
               kssp_pkg::PH_MOD_DOWN: begin
                  result.event_res = kssp_pkg::EV_MOD_DOWN;
                  result.modifier  = hi;
                  state_next.phase = kssp_pkg::PH_MOD_KEY_DOWN;
               end
               kssp_pkg::PH_MOD_KEY_DOWN: begin
                  result.event_res = kssp_pkg::EV_KEY_DOWN;
                  result.key_code  = lo;
                  state_next.phase = kssp_pkg::PH_MOD_KEY_UP;
               end
               kssp_pkg::PH_MOD_KEY_UP: begin
                  result.event_res = kssp_pkg::EV_KEY_UP;
                  result.key_code  = lo;
                  state_next.phase = kssp_pkg::PH_MOD_UP;
               end
               kssp_pkg::PH_MOD_UP: begin
                  result.event_res = kssp_pkg::EV_MOD_UP;
                  result.modifier  = hi;
                  state_next.phase = kssp_pkg::PH_FETCH;
               end
               kssp_pkg::PH_WAIT: begin
                  // A wait of zero wraps to 255 here, which gives 256 steps.
                  state_next.wait_count = state.wait_count - 8'd1;
                  if (state_next.wait_count == 8'd0) begin
                     state_next.phase = kssp_pkg::PH_FETCH;
                  end
               end
               default: begin
                  state_next.phase = kssp_pkg::PH_IDLE;
               end
            endcase
         end else begin
            state_next.tick_count = tick_inc;
         end
      end

      result.activity_led = state_next.led_state;
      result.running      = (state_next.phase != kssp_pkg::PH_IDLE);
   end

endmodule
